### rtl/bca_pkg.sv
// Shared constants, types and codes of the block chain allocator.
`timescale 1ns / 1ps

package bca_pkg;

   localparam int NUM_BLOCKS = 128;
   localparam int NUM_SLOTS  = 16;

   localparam int BLK_W  = $clog2(NUM_BLOCKS);
   localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam int COUNT_W  = 8;
   localparam int FSLOT_W  = 4;
   localparam int STATUS_W = 3;
   localparam int FBLK_W   = 7;
   localparam int CNT_W    = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;

   localparam logic [LINK_W-1:0] END_LINK = LINK_W'(NUM_BLOCKS);

   typedef enum logic {
      CMD_CREATE = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_NOSPACE  = 3'd2,
      STAT_NOSLOT   = 3'd3,
      STAT_BADCOUNT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_EVAL,
      S_SCAN,
      S_LINK,
      S_LINK_END,
      S_DEL_READ,
      S_DEL_STEP,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [COUNT_W-1:0]   block_count;
      logic                 contiguous;
      logic [FSLOT_W-1:0]   file_slot;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [FSLOT_W-1:0]   slot_given;
      logic [FBLK_W-1:0]    first_block;
   } rsp_type;

endpackage

### rtl/block_chain_allocator.sv
// Top level of the block chain allocator: stream ports and result register.
//
// Allocates blocks from a pool of 128 for a table of 16 files, one request at a
// time; req_tready is low while a request is in work. After reset the block map
// is cleared one block per cycle, so req_tready stays low until every block is
// cleared. A create checks the table and the count, then scans the block map
// one block per cycle until it has found the run (contiguous) or enough free
// blocks (chained), then makes a second pass one block per cycle that marks and
// links the blocks, and a last step writes the end link. A delete walks the
// chain through S_DEL_READ and S_DEL_STEP for each block, since each step reads
// the next link from the link memory before freeing the block. A finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module block_chain_allocator
   import bca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // block_count[7:0], contiguous[8], file_slot[12:9], zero
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[2:0], slot_given[6:3], first_block[13:7], zero
);

   req_type eng_req;
   rsp_type eng_rsp;
   logic    eng_rsp_valid;
   logic    eng_rsp_ready;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign eng_req.cmd         = cmd_type'(req_tuser);
   assign eng_req.block_count = req_tdata[7:0];
   assign eng_req.contiguous  = req_tdata[8];
   assign eng_req.file_slot   = req_tdata[12:9];

   bca_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (eng_req),
      .rsp_valid (eng_rsp_valid),
      .rsp_ready (eng_rsp_ready),
      .rsp       (eng_rsp)
   );

   assign eng_rsp_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_rsp_ready) begin
         rsp_valid_in = eng_rsp_valid;
         if (eng_rsp_valid) begin
            rsp_data_in = eng_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.first_block, rsp_data_ff.slot_given,
                        rsp_data_ff.status};

endmodule

### rtl/bca_link_ram.sv
// Next-link memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bca_link_ram
   import bca_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [BLK_W-1:0]  wr_addr,
   input  logic [LINK_W-1:0] wr_data,
   input  logic [BLK_W-1:0]  rd_addr,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] mem [NUM_BLOCKS];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bca_engine.sv
// Allocation sequencer: block map, file table, scan, link and delete walk.
`timescale 1ns / 1ps

module bca_engine
   import bca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                contig_ff, contig_in;
   logic [FSLOT_W-1:0]  fslot_ff, fslot_in;
   logic [LINK_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [CNT_W-1:0]    got_ff, got_in;
   logic [BLK_W-1:0]    last_ff, last_in;
   logic [BLK_W-1:0]    first_ff, first_in;
   logic [SLOT_W-1:0]   free_slot_ff, free_slot_in;
   logic [LINK_W-1:0]   steps_ff, steps_in;
   status_type          status_ff, status_in;
   logic [NUM_SLOTS-1:0]  slot_valid_ff, slot_valid_in;
   logic [BLK_W-1:0]    slot_first_ff [NUM_SLOTS];

   logic                used_mem [NUM_BLOCKS];
   logic                used_rd_ff;
   logic                used_wr_en;
   logic                used_wr_data;
   logic [BLK_W-1:0]    used_rd_addr;

   logic                sf_wr_en;
   logic [BLK_W-1:0]    blk_idx;
   logic                blk_used;
   logic [CNT_W-1:0]    count_w;
   logic [CNT_W-1:0]    run_inc;
   logic [CNT_W-1:0]    got_inc;
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;
   logic [SLOT_W-1:0]   slot_idx;
   logic                slot_bad;

   logic                ram_wr_en;
   logic [BLK_W-1:0]    ram_wr_addr;
   logic [LINK_W-1:0]   ram_wr_data;
   logic [BLK_W-1:0]    ram_rd_addr;
   logic [LINK_W-1:0]   ram_rd_data;

   bca_link_ram u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (!slot_valid_ff[s]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(s);
         end
      end
   end

   assign blk_idx      = idx_ff[BLK_W-1:0];
   assign blk_used     = used_rd_ff;
   assign used_rd_addr = idx_in[BLK_W-1:0];
   assign count_w      = CNT_W'(count_ff);
   assign run_inc      = run_ff + CNT_W'(1);
   assign got_inc      = got_ff + CNT_W'(1);
   assign slot_idx     = SLOT_W'(fslot_ff);
   assign slot_bad     = (32'(fslot_ff) >= NUM_SLOTS) || !slot_valid_ff[slot_idx];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      contig_in     = contig_ff;
      fslot_in      = fslot_ff;
      idx_in        = idx_ff;
      run_in        = run_ff;
      got_in        = got_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      free_slot_in  = free_slot_ff;
      steps_in      = steps_ff;
      status_in     = status_ff;
      slot_valid_in = slot_valid_ff;
      used_wr_en    = 1'b0;
      used_wr_data  = 1'b0;
      sf_wr_en      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = blk_idx;
      ram_wr_data   = END_LINK;
      ram_rd_addr   = blk_idx;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req.cmd;
               count_in  = req.block_count;
               contig_in = req.contiguous;
               fslot_in  = req.file_slot;
               state_in  = S_EVAL;
            end
         end
         S_CLEAR: begin
            used_wr_en   = 1'b1;
            used_wr_data = 1'b0;
            idx_in       = idx_ff + LINK_W'(1);
            if (idx_ff == LINK_W'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_EVAL: begin
            idx_in   = '0;
            run_in   = '0;
            got_in   = '0;
            steps_in = '0;
            if (cmd_ff == CMD_CREATE) begin
               free_slot_in = free_idx;
               if (!free_found) begin
                  status_in = STAT_FULL;
                  state_in  = S_DONE;
               end else if (count_w == '0) begin
                  status_in = STAT_BADCOUNT;
                  state_in  = S_DONE;
               end else if (count_w > CNT_W'(NUM_BLOCKS)) begin
                  status_in = STAT_NOSPACE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (slot_bad) begin
                  status_in = STAT_NOSLOT;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = LINK_W'(slot_first_ff[slot_idx]);
                  state_in = S_DEL_READ;
               end
            end
         end
         S_SCAN: begin
            if (!blk_used && run_inc == count_w) begin
               idx_in   = contig_ff ?
                          LINK_W'(CNT_W'(idx_ff) + CNT_W'(1) - count_w) : '0;
               state_in = S_LINK;
            end else begin
               run_in = blk_used ? (contig_ff ? '0 : run_ff) : run_inc;
               idx_in = idx_ff + LINK_W'(1);
               if (idx_ff == LINK_W'(NUM_BLOCKS - 1)) begin
                  status_in = STAT_NOSPACE;
                  state_in  = S_DONE;
               end
            end
         end
         S_LINK: begin
            idx_in = idx_ff + LINK_W'(1);
            if (!blk_used) begin
               used_wr_en   = 1'b1;
               used_wr_data = 1'b1;
               if (got_ff == '0) begin
                  first_in = blk_idx;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = last_ff;
                  ram_wr_data = idx_ff;
               end
               last_in = blk_idx;
               got_in  = got_inc;
               if (got_inc == count_w) begin
                  state_in = S_LINK_END;
               end
            end
         end
         S_LINK_END: begin
            ram_wr_en                   = 1'b1;
            ram_wr_addr                 = last_ff;
            ram_wr_data                 = END_LINK;
            slot_valid_in[free_slot_ff] = 1'b1;
            sf_wr_en                    = 1'b1;
            status_in                   = STAT_OK;
            state_in                    = S_DONE;
         end
         S_DEL_READ: begin
            if (idx_ff >= END_LINK || steps_ff == LINK_W'(NUM_BLOCKS)) begin
               slot_valid_in[slot_idx] = 1'b0;
               status_in               = STAT_OK;
               state_in                = S_DONE;
            end else begin
               state_in = S_DEL_STEP;
            end
         end
         S_DEL_STEP: begin
            used_wr_en       = 1'b1;
            used_wr_data     = 1'b0;
            ram_wr_en        = 1'b1;
            ram_wr_addr      = blk_idx;
            ram_wr_data      = END_LINK;
            idx_in           = ram_rd_data;
            steps_in         = steps_ff + LINK_W'(1);
            state_in         = S_DEL_READ;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.status      = status_ff;
      rsp.slot_given  = '0;
      rsp.first_block = '0;
      if (cmd_ff == CMD_CREATE && status_ff == STAT_OK) begin
         rsp.slot_given  = FSLOT_W'(free_slot_ff);
         rsp.first_block = FBLK_W'(first_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         slot_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (used_wr_en) begin
         used_mem[blk_idx] <= used_wr_data;
      end
      used_rd_ff <= used_mem[used_rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      count_ff     <= count_in;
      contig_ff    <= contig_in;
      fslot_ff     <= fslot_in;
      run_ff       <= run_in;
      got_ff       <= got_in;
      last_ff      <= last_in;
      first_ff     <= first_in;
      free_slot_ff <= free_slot_in;
      steps_ff     <= steps_in;
      status_ff    <= status_in;
      if (sf_wr_en) begin
         slot_first_ff[free_slot_ff] <= first_ff;
      end
   end

endmodule
